// ===== hw/rtl/rns_pkg.sv =====
// ----------------------------------------------------------------------------
// rns_pkg
// Types and codes shared by the radius neighbor search block and its checker.
// ----------------------------------------------------------------------------
package rns_pkg;

	localparam int FIELD_COORD_W    = 16;
	localparam int NEIGHBOR_INDEX_W = 10;
	localparam int RADIUS_W         = 36;
	localparam int CFG_ADDR_W       = 4;
	localparam int CFG_DATA_W       = 64;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_QUERY = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	// register index, taken from the 8-byte aligned address bit
	localparam logic REG_RADIUS = 1'b0;

	typedef struct packed {
		logic [1:0]                      cmd;
		logic                            batch;
		logic signed [FIELD_COORD_W-1:0] x;
		logic signed [FIELD_COORD_W-1:0] y;
		logic signed [FIELD_COORD_W-1:0] z;
	} point_t;

	typedef struct packed {
		logic [NEIGHBOR_INDEX_W-1:0] neighbor_index;
		logic                        found;
		logic                        last;
		logic                        truncated;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} scan_state_t;

endpackage

// ===== hw/rtl/radius_neighbor_search.sv =====
// ----------------------------------------------------------------------------
// radius_neighbor_search
// Fixed-radius neighbor search by exhaustive scan over a batch of stored
// support points.
//
// Loads, clears and no-op requests complete without leaving the idle state.
// During a query the scan reads one support point per cycle, while the
// result output is not stalled, from the single-port point memory, and each
// read goes through a three-stage distance pipeline (read, difference and
// square, sum and compare). A stalled result output stalls the scan. Matches
// leave in ascending store index; the last result of a query is flagged. No
// clearing pass is needed after reset: the fill count bounds every read.
// ----------------------------------------------------------------------------
module radius_neighbor_search
	import rns_pkg::*;
#(
	parameter int SUPPORT_DEPTH = 1024,
	parameter int MAX_BATCHES   = 2,
	parameter int MAX_NEIGHBORS = 64,
	parameter int COORD_BITS    = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  point_valid,
	output logic                  point_ready,
	input  point_t                point,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int AW    = (SUPPORT_DEPTH > 1) ? $clog2(SUPPORT_DEPTH) : 1;
	localparam int CW    = $clog2(SUPPORT_DEPTH + 1);
	localparam int BW    = (MAX_BATCHES > 1) ? $clog2(MAX_BATCHES) : 1;
	localparam int NW    = $clog2(MAX_NEIGHBORS + 1);
	localparam int C     = COORD_BITS;
	localparam int SQ_W  = 2 * C;
	localparam int SUM_W = 2 * C + 2;
	localparam int CMP_W = (SUM_W > RADIUS_W) ? SUM_W : RADIUS_W;

	logic [RADIUS_W-1:0] radius_q;
	logic [CW-1:0]       fill_q;
	logic [CW-1:0]       bstart_q [MAX_BATCHES];
	logic [CW-1:0]       bsize_q  [MAX_BATCHES];

	scan_state_t state_q, state_d;
	logic [AW-1:0] scan_addr_q;
	logic [CW-1:0] scan_left_q;
	logic [C-1:0]  qx_q, qy_q, qz_q;

	logic [3*C-1:0] mem [SUPPORT_DEPTH];

	logic           v_s1, end_s1;
	logic [AW-1:0]  idx_s1;
	logic [3*C-1:0] rd_s1;

	logic            v_s2, end_s2;
	logic [AW-1:0]   idx_s2;
	logic [SQ_W-1:0] sqx_s2, sqy_s2, sqz_s2;

	logic          v_s3, end_s3, match_s3;
	logic [AW-1:0] idx_s3;

	logic          pend_valid_q;
	logic [AW-1:0] pend_idx_q;
	logic [NW-1:0] hits_q;
	logic          dropped_q;

	logic    out_valid_q;
	result_t out_q;

	logic          point_accept, is_load, is_query, is_clear;
	logic [C-1:0]  cx, cy, cz;
	logic          b_ok, load_ok;
	logic [BW-1:0] bidx;
	logic [CW-1:0] cur_start, cur_size;
	logic          en, issue, finish_emit, room, emit_mid;

	logic signed [C:0]       dx, dy, dz;
	logic signed [2*C+1:0]   px, py, pz;
	logic [SUM_W-1:0]        dist_sum;

	// ---------------------------------------------------------------- request decode
	assign point_accept = point_valid & point_ready;
	assign is_load      = point.cmd == CMD_LOAD;
	assign is_query     = point.cmd == CMD_QUERY;
	assign is_clear     = point.cmd == CMD_CLEAR;

	assign cx = C'($unsigned(point.x));
	assign cy = C'($unsigned(point.y));
	assign cz = C'($unsigned(point.z));

	assign b_ok = 32'(point.batch) < MAX_BATCHES;
	assign bidx = BW'(point.batch);

	always_comb begin
		cur_start = '0;
		cur_size  = '0;
		if (b_ok) begin
			cur_start = bstart_q[bidx];
			cur_size  = bsize_q[bidx];
		end
	end

	assign load_ok = point_accept & is_load & b_ok & (fill_q < CW'(SUPPORT_DEPTH)) &
		((cur_size == '0) ||
		 ((CW+1)'(cur_start) + (CW+1)'(cur_size) == (CW+1)'(fill_q)));

	// ---------------------------------------------------------------- config port
	assign pready = 1'b1;
	assign prdata = (paddr[CFG_ADDR_W-1] == REG_RADIUS) ? CFG_DATA_W'(radius_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
		end else if (psel && penable && pwrite && pready &&
		             paddr[CFG_ADDR_W-1] == REG_RADIUS) begin
			radius_q <= pwdata[RADIUS_W-1:0];
		end
	end

	// ---------------------------------------------------------------- store bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			for (int i = 0; i < MAX_BATCHES; i++) begin
				bstart_q[i] <= '0;
				bsize_q[i]  <= '0;
			end
		end else if (point_accept && is_clear) begin
			fill_q <= '0;
			for (int i = 0; i < MAX_BATCHES; i++) begin
				bstart_q[i] <= '0;
				bsize_q[i]  <= '0;
			end
		end else if (load_ok) begin
			if (cur_size == '0) begin
				bstart_q[bidx] <= fill_q;
			end
			bsize_q[bidx] <= cur_size + CW'(1);
			fill_q        <= fill_q + CW'(1);
		end
	end

	// ---------------------------------------------------------------- point memory
	always_ff @(posedge clk) begin
		if (load_ok) begin
			mem[fill_q[AW-1:0]] <= {cx, cy, cz};
		end
		if (issue) begin
			rd_s1 <= mem[scan_addr_q];
		end
	end

	// ---------------------------------------------------------------- sequencer
	assign en = !out_valid_q || result_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (point_accept && is_query) begin
					state_d = (cur_size == '0) ? ST_FINISH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (en && scan_left_q == CW'(1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (en && v_s3 && end_s3) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (en) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		point_ready = 1'b0;
		issue       = 1'b0;
		finish_emit = 1'b0;
		unique case (state_q)
			ST_IDLE:   point_ready = 1'b1;
			ST_SCAN:   issue       = en;
			ST_DRAIN:  ;
			ST_FINISH: finish_emit = en;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_left_q <= '0;
		end else begin
			state_q <= state_d;
			if (point_accept && is_query) begin
				scan_left_q <= cur_size;
			end else if (issue) begin
				scan_left_q <= scan_left_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (point_accept && is_query) begin
			scan_addr_q <= cur_start[AW-1:0];
			qx_q        <= cx;
			qy_q        <= cy;
			qz_q        <= cz;
		end else if (issue) begin
			scan_addr_q <= scan_addr_q + AW'(1);
		end
	end

	// ---------------------------------------------------------------- distance pipeline
	always_comb begin
		dx = $signed({qx_q[C-1], qx_q}) - $signed({rd_s1[3*C-1], rd_s1[3*C-1:2*C]});
		dy = $signed({qy_q[C-1], qy_q}) - $signed({rd_s1[2*C-1], rd_s1[2*C-1:C]});
		dz = $signed({qz_q[C-1], qz_q}) - $signed({rd_s1[C-1], rd_s1[C-1:0]});
		px = dx * dx;
		py = dy * dy;
		pz = dz * dz;
		dist_sum = SUM_W'(sqx_s2) + SUM_W'(sqy_s2) + SUM_W'(sqz_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			end_s1   <= scan_left_q == CW'(1);
			idx_s1   <= scan_addr_q;
			end_s2   <= end_s1;
			idx_s2   <= idx_s1;
			sqx_s2   <= px[SQ_W-1:0];
			sqy_s2   <= py[SQ_W-1:0];
			sqz_s2   <= pz[SQ_W-1:0];
			end_s3   <= end_s2;
			idx_s3   <= idx_s2;
			match_s3 <= CMP_W'(dist_sum) < CMP_W'(radius_q);
		end
	end

	// ---------------------------------------------------------------- result collection
	assign room     = hits_q < NW'(MAX_NEIGHBORS);
	assign emit_mid = en & v_s3 & match_s3 & room & pend_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			hits_q       <= '0;
			dropped_q    <= 1'b0;
		end else if (point_accept && is_query) begin
			pend_valid_q <= 1'b0;
			hits_q       <= '0;
			dropped_q    <= 1'b0;
		end else if (finish_emit) begin
			pend_valid_q <= 1'b0;
		end else if (en && v_s3 && match_s3) begin
			if (room) begin
				pend_valid_q <= 1'b1;
				hits_q       <= hits_q + NW'(1);
			end else begin
				dropped_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s3 && match_s3 && room) begin
			pend_idx_q <= idx_s3;
		end
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_mid || finish_emit) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_mid) begin
			out_q.neighbor_index <= NEIGHBOR_INDEX_W'(pend_idx_q);
			out_q.found          <= 1'b1;
			out_q.last           <= 1'b0;
			out_q.truncated      <= 1'b0;
		end else if (finish_emit) begin
			out_q.neighbor_index <= pend_valid_q ? NEIGHBOR_INDEX_W'(pend_idx_q) : '0;
			out_q.found          <= pend_valid_q;
			out_q.last           <= 1'b1;
			out_q.truncated      <= pend_valid_q & dropped_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// ===== hw/rtl/rns_checker.sv =====
// ----------------------------------------------------------------------------
// rns_checker
// Port-level checks on the radius neighbor search block, bound to its top.
// ----------------------------------------------------------------------------
module rns_checker
	import rns_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    point_valid,
	input logic    point_ready,
	input point_t  point,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_non_query_keeps_ready: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && point_ready && point.cmd != CMD_QUERY |=> point_ready)
		else $error("non-query request blocked the input");

	a_no_match_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.found |->
			result.last && !result.truncated && result.neighbor_index == '0)
		else $error("malformed no-match result");

	a_truncated_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.truncated |-> result.last && result.found)
		else $error("truncated flag off the final match");

	a_busy_until_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> !point_ready)
		else $error("input ready before the query finished");

endmodule

bind radius_neighbor_search rns_checker u_rns_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.point_valid  (point_valid),
	.point_ready  (point_ready),
	.point        (point),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
